// ===== sv/irans_pkg.sv =====
package irans_pkg;

  // Fixed widths of the coder state and of a renormalization word.
  localparam int STATE_W      = 32;
  localparam int WORD_BITS    = 16;
  localparam int RENORM_SHIFT = 22;
  localparam int CNT_W        = $clog2(STATE_W);

  // Operation codes carried in the kind field.
  localparam logic [1:0] KIND_SYM   = 2'd0;
  localparam logic [1:0] KIND_RAW   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  lane;
    logic [10:0] sym_freq;
    logic [9:0]  sym_cum;
    logic [3:0]  raw_bits;
    logic [7:0]  raw_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_lane;
    logic [STATE_W-1:0] out_data;
    logic               is_final;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RENORM,
    ST_DIV,
    ST_FLUSH
  } state_e;

endpackage

// ===== sv/irans_stream_if.sv =====
interface irans_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/irans_div.sv =====
module irans_div #(
  parameter int DIVISOR_W = 15
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [irans_pkg::STATE_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]         divisor_i,
  output logic                         done_o,
  output logic [irans_pkg::STATE_W-1:0] quot_o,
  output logic [DIVISOR_W-1:0]         rem_o
);
  import irans_pkg::*;

  // Restoring radix-2 divider: one quotient bit per cycle. The dividend
  // shifts out of the top of quot_q while quotient bits shift in below.
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [STATE_W-1:0]   quot_q, quot_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] dvs_q, dvs_d;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  assign trial = {rem_q, quot_q[STATE_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quot_d = {quot_q[STATE_W-2:0], ge};
      rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(STATE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== sv/interleaved_rans_encoder_top.sv =====
// A modelled or bypass item holds the block from its acceptance to the next acceptance:
// a renormalization check, the divider run (one quotient bit at a time), a write-back and
// the idle state in which the next item is taken. A flush passes through the flush state.
// A renormalization word or a final state is registered into the output register in the
// check or the flush; a stalled output register holds the check or the flush until it drains.
// Reset is asynchronous, active low, and loads every lane with STATE_INIT.
module interleaved_rans_encoder_top #(
  parameter int NUM_LANES  = 8,
  parameter int PROB_BITS  = 10,
  parameter int STATE_INIT = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  irans_stream_if.sink   in_i,
  irans_stream_if.source out_o
);
  import irans_pkg::*;

  // Only eight lanes can be addressed by the three-bit lane field, so no more
  // than eight states are ever kept.
  localparam int LANE_CNT = (NUM_LANES < 8) ? NUM_LANES : 8;
  localparam int LIDX_W   = (LANE_CNT > 1) ? $clog2(LANE_CNT) : 1;
  // The divisor holds either an 11-bit symbol frequency or a power of two up to 2^PROB_BITS.
  localparam int F_W      = (PROB_BITS + 1 > 11) ? PROB_BITS + 1 : 11;
  localparam int C_W      = (PROB_BITS > 10) ? PROB_BITS : 10;
  localparam int THR_W    = F_W + RENORM_SHIFT;

  localparam logic [3:0]         PROB_BITS_4 = 4'(PROB_BITS);
  localparam logic [3:0]         LANE_CNT_4  = 4'(LANE_CNT);
  localparam logic [STATE_W-1:0] INIT_VAL    = STATE_W'(STATE_INIT);

  state_e state_q, state_d;

  // Per-lane coder states.
  logic [STATE_W-1:0] lane_state_q [LANE_CNT];

  // Operands of the item in flight.
  logic [2:0]         lane_q;
  logic [STATE_W-1:0] x_q;
  logic [F_W-1:0]     f_q;
  logic [C_W-1:0]     c_q;

  // Output register that decouples the result from the downstream stall.
  logic      out_vld_q;
  out_item_t out_q;
  logic      out_free;

  // Decode of the offered item.
  in_item_t       item;
  logic           lane_ok;
  logic [3:0]     k_sat;
  logic [3:0]     sh;
  logic [C_W-1:0] raw_mask;
  logic [F_W-1:0] f_new;
  logic [C_W-1:0] c_new;
  logic           go_code;
  logic           go_flush;

  // Sequencer controls.
  logic in_ready;
  logic load;
  logic emit_word;
  logic emit_final;
  logic div_start;
  logic write_back;

  // Renormalization check and divider interface.
  logic [THR_W-1:0]   thr;
  logic               need_renorm;
  logic [STATE_W-1:0] div_dividend;
  logic               div_done;
  logic [STATE_W-1:0] div_quot;
  logic [F_W-1:0]     div_rem;
  logic [STATE_W-1:0] x_next;

  assign item    = in_i.data;
  assign lane_ok = {1'b0, item.lane} < LANE_CNT_4;

  // A bypass of k raw bits codes with frequency 2^(P-k) and a cumulative count
  // of the value scaled by the same power of two. Wide k saturates at P.
  assign k_sat    = (item.raw_bits > PROB_BITS_4) ? PROB_BITS_4 : item.raw_bits;
  assign sh       = PROB_BITS_4 - k_sat;
  assign raw_mask = ~({C_W{1'b1}} << k_sat);

  always_comb begin
    if (item.kind == KIND_RAW) begin
      f_new = F_W'(1) << sh;
      c_new = (C_W'(item.raw_value) & raw_mask) << sh;
    end else begin
      f_new = F_W'(item.sym_freq);
      c_new = C_W'(item.sym_cum);
    end
  end

  // Items on an absent lane, of the unused kind, or with a zero symbol
  // frequency are taken and dropped without touching any lane.
  assign go_code  = lane_ok && ((item.kind == KIND_RAW) ||
                                ((item.kind == KIND_SYM) && (item.sym_freq != '0)));
  assign go_flush = lane_ok && (item.kind == KIND_FLUSH);

  assign out_free = !out_vld_q || out_o.ready;

  // The state is renormalized when it reaches f << 22, which keeps the
  // encoded state inside 32 bits.
  assign thr          = {f_q, {RENORM_SHIFT{1'b0}}};
  assign need_renorm  = THR_W'(x_q) >= thr;
  assign div_dividend = need_renorm ? (x_q >> WORD_BITS) : x_q;

  irans_div #(
    .DIVISOR_W (F_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (f_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // New state: (x / f) << P plus x % f plus the cumulative count.
  assign x_next = STATE_W'(div_quot << PROB_BITS) + STATE_W'(div_rem) + STATE_W'(c_q);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          if (go_code) begin
            state_d = ST_RENORM;
          end else if (go_flush) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_RENORM: begin
        if (!need_renorm || out_free) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    load       = 1'b0;
    emit_word  = 1'b0;
    emit_final = 1'b0;
    div_start  = 1'b0;
    write_back = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        load     = in_i.valid;
      end
      ST_RENORM: begin
        if (!need_renorm || out_free) begin
          div_start = 1'b1;
          emit_word = need_renorm;
        end
      end
      ST_DIV: begin
        write_back = div_done;
      end
      ST_FLUSH: begin
        emit_final = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      for (int i = 0; i < LANE_CNT; i++) begin
        lane_state_q[i] <= INIT_VAL;
      end
    end else begin
      state_q <= state_d;
      if (emit_word || emit_final) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (write_back) begin
        lane_state_q[lane_q[LIDX_W-1:0]] <= x_next;
      end else if (emit_final) begin
        lane_state_q[lane_q[LIDX_W-1:0]] <= INIT_VAL;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lane_q <= item.lane;
      x_q    <= lane_state_q[item.lane[LIDX_W-1:0]];
      f_q    <= f_new;
      c_q    <= c_new;
    end
    if (emit_word) begin
      out_q.out_lane <= lane_q;
      out_q.out_data <= STATE_W'(x_q[WORD_BITS-1:0]);
      out_q.is_final <= 1'b0;
    end else if (emit_final) begin
      out_q.out_lane <= lane_q;
      out_q.out_data <= x_q;
      out_q.is_final <= 1'b1;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // The dividend handed to the divider is always below the renormalization
  // threshold.
  a_dividend_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (THR_W'(div_dividend) < thr))
    else $error("dividend not below renormalization threshold");

  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  // The remainder written back is below the frequency.
  a_rem_below_f: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_rem < f_q))
    else $error("remainder not below frequency");

  // A word that cannot be emitted holds the sequencer in the check.
  a_renorm_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RENORM && need_renorm && !out_free) |=> (state_q == ST_RENORM))
    else $error("renormalization word dropped on stall");

  // The divider is started only when the sequencer comes from the idle state or from the check.
  a_start_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_RENORM))
    else $error("divider started out of sequence");

endmodule
